[hw/rtl/eit_pkg.sv]
`default_nettype none
package eit_pkg;

   localparam int LIST_COUNT      = 16;
   localparam int LIST_DEPTH      = 32;
   localparam int DESCRIPTOR_BITS = 10;

   localparam int HANDLE_BASE = 200;
   localparam int ENTRIES     = LIST_COUNT * LIST_DEPTH;
   localparam int LIST_W      = (LIST_COUNT > 1) ? $clog2(LIST_COUNT) : 1;
   localparam int IDX_W       = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int POS_W       = $clog2(LIST_DEPTH + 1);
   localparam int ADDR_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   // ready bits: 0x001 and 0x004
   localparam logic [2:0] READY_MASK = 3'b101;

   typedef enum logic [2:0] {
      OP_ALLOC = 3'd0,
      OP_ADD   = 3'd1,
      OP_DEL   = 3'd2,
      OP_MOD   = 3'd3,
      OP_SCAN  = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_BAD_HANDLE = 3'd1,
      ST_NO_ROOM    = 3'd2,
      ST_NOT_FOUND  = 3'd3,
      ST_PRESENT    = 3'd4,
      ST_INVALID    = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      DEC_REPLY = 2'd0,
      DEC_FIND  = 2'd1,
      DEC_SCAN  = 2'd2
   } dec_type;

   typedef struct packed {
      logic capture;
      logic decode;
      logic find;
      logic shift;
      logic scan;
      logic reply;
   } eit_cmd_type;

   typedef struct packed {
      dec_type dec;
      logic    find_hit;
      logic    find_miss;
      logic    is_del;
      logic    shift_done;
      logic    scan_done;
      logic    out_free;
   } eit_sts_type;

endpackage
`default_nettype wire

[hw/rtl/event_interest_table.sv]
// Channel | Dir | Ports                         | Carries
// req     | in  | req_tvalid/tready/tdata/tuser | one command transaction
// rsp     | out | rsp_tvalid/tready/tdata/tlast | one or more results per command
//
// One command at a time. Allocate and rejected commands go from decode straight
// to reply, where the result is loaded into the output register.
// Add, modify and scan walk the list one entry per cycle through the single
// entry memory read port, a scan pausing while the rsp side stalls. Delete also
// moves each later entry down one place.
// Synchronous reset frees all lists; entry memory is not cleared.
// A stalled rsp side holds a scan on its next ready entry until the output
// register drains.
`default_nettype none
module event_interest_table import eit_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // list_handle[9:0], descriptor[19:10], event_mask[51:20],
   // user_data[115:52], max_events[121:116], zero pad
   input  wire logic [127:0] req_tdata,
   // command[2:0]
   input  wire logic [2:0]   req_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // status[2:0], result_value[12:3], ready_events[15:13], ready_data[79:16]
   output logic [79:0]       rsp_tdata,
   output logic              rsp_tlast
);

   eit_cmd_type cmd;
   eit_sts_type sts;

   logic [2:0]  o_status, o_events;
   logic [9:0]  o_value;
   logic [63:0] o_data;

   eit_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   eit_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .in_command    (req_tuser),
      .in_handle     (req_tdata[9:0]),
      .in_descriptor (req_tdata[19:10]),
      .in_mask       (req_tdata[51:20]),
      .in_data       (req_tdata[115:52]),
      .in_max        (req_tdata[121:116]),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .out_status    (o_status),
      .out_value     (o_value),
      .out_evbits    (o_events),
      .out_data      (o_data),
      .out_last      (rsp_tlast)
   );

   assign rsp_tdata = {o_data, o_events, o_value, o_status};

endmodule
`default_nettype wire

[hw/rtl/eit_ctrl.sv]
`default_nettype none
module eit_ctrl import eit_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  req_tvalid,
   output logic       req_tready,
   input  wire eit_sts_type sts,
   output eit_cmd_type cmd
);

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_DECODE = 6'b000010,
      S_FIND   = 6'b000100,
      S_SHIFT  = 6'b001000,
      S_SCAN   = 6'b010000,
      S_REPLY  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
            if (req_tvalid) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.decode = 1'b1;
            unique case (sts.dec)
               DEC_FIND: state_in = S_FIND;
               DEC_SCAN: state_in = S_SCAN;
               default:  state_in = S_REPLY;
            endcase
         end
         S_FIND: begin
            cmd.find = 1'b1;
            if (sts.find_hit) begin
               state_in = sts.is_del ? S_SHIFT : S_REPLY;
            end else if (sts.find_miss) begin
               state_in = S_REPLY;
            end
         end
         S_SHIFT: begin
            cmd.shift = 1'b1;
            if (sts.shift_done) begin
               state_in = S_REPLY;
            end
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_done) begin
               state_in = S_REPLY;
            end
         end
         S_REPLY: begin
            cmd.reply = 1'b1;
            if (sts.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule
`default_nettype wire

[hw/rtl/eit_dp.sv]
`default_nettype none
module eit_dp import eit_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire eit_cmd_type cmd,
   output eit_sts_type      sts,
   input  wire logic [2:0]  in_command,
   input  wire logic [9:0]  in_handle,
   input  wire logic [9:0]  in_descriptor,
   input  wire logic [31:0] in_mask,
   input  wire logic [63:0] in_data,
   input  wire logic [5:0]  in_max,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [2:0]       out_status,
   output logic [9:0]       out_value,
   output logic [2:0]       out_evbits,
   output logic [63:0]      out_data,
   output logic             out_last
);

   typedef struct packed {
      logic [DESCRIPTOR_BITS-1:0] desc;
      logic [31:0]                mask;
      logic [63:0]                data;
   } entry_type;

   entry_type mem [ENTRIES];

   // captured transaction
   logic [2:0]  op_ff;
   logic [9:0]  hdl_ff;
   logic [DESCRIPTOR_BITS-1:0] desc_ff;
   logic [31:0] emask_ff;
   logic [63:0] udata_ff;
   logic [5:0]  maxev_ff;

   // per-list state
   logic             use_ff  [LIST_COUNT];
   logic [POS_W-1:0] fcnt_ff [LIST_COUNT];

   logic [LIST_W-1:0] lst_ff;
   logic [POS_W-1:0]  fill_ff;

   // walk pipeline
   logic [POS_W-1:0] rq_ff, pidx_ff, cnt_ff;
   logic             pv_ff;
   entry_type        rd_ff;

   // pending result
   logic [2:0]  hst_ff;
   logic [9:0]  hval_ff;
   logic [2:0]  hev_ff;
   logic [63:0] hdat_ff;

   // output register
   logic        ov_ff;
   logic [2:0]  ost_ff, oev_ff;
   logic [9:0]  oval_ff;
   logic [63:0] odat_ff;
   logic        olast_ff;

   function automatic logic [ADDR_W-1:0] ent_addr(logic [LIST_W-1:0] l, logic [IDX_W-1:0] i);
      return ADDR_W'(ADDR_W'(l) * ADDR_W'(LIST_DEPTH) + ADDR_W'(i));
   endfunction

   // decode
   logic              free_found;
   logic [LIST_W-1:0] free_idx;
   logic [9:0]        hnum;
   logic              in_range, handle_ok;
   logic [LIST_W-1:0] hidx;
   logic [POS_W-1:0]  cur_fill;
   dec_type           dec;
   logic [2:0]        dec_st;
   logic [9:0]        dec_val;

   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = LIST_COUNT - 1; i >= 0; i--) begin
         if (!use_ff[i]) begin
            free_found = 1'b1;
            free_idx   = LIST_W'(i);
         end
      end
   end

   assign hnum      = hdl_ff - 10'(HANDLE_BASE);
   assign in_range  = (hdl_ff >= 10'(HANDLE_BASE)) && (32'(hnum) < 32'(LIST_COUNT));
   assign hidx      = hnum[LIST_W-1:0];
   assign handle_ok = in_range && use_ff[hidx];
   assign cur_fill  = fcnt_ff[hidx];

   always_comb begin
      dec     = DEC_REPLY;
      dec_st  = ST_OK;
      dec_val = '0;
      unique case (op_ff) inside
         OP_ALLOC: begin
            dec_st  = free_found ? ST_OK : ST_NO_ROOM;
            dec_val = free_found ? 10'(10'(HANDLE_BASE) + 10'(free_idx)) : '0;
         end
         OP_ADD, OP_DEL, OP_MOD: begin
            if (!handle_ok) begin
               dec_st = ST_BAD_HANDLE;
            end else if (op_ff == OP_ADD && cur_fill >= POS_W'(LIST_DEPTH)) begin
               dec_st = ST_NO_ROOM;
            end else begin
               dec = DEC_FIND;
            end
         end
         OP_SCAN: begin
            if (!handle_ok) begin
               dec_st = ST_BAD_HANDLE;
            end else begin
               dec = DEC_SCAN;
            end
         end
         default: dec_st = ST_INVALID;
      endcase
   end

   // walk
   logic             out_free, walking, ready_hit, hit, adv, issue, scan_emit;
   logic [POS_W-1:0] maxeff, cnt_after;
   logic [2:0]       ev;

   assign out_free  = !ov_ff || rsp_tready;
   assign walking   = cmd.find || cmd.shift || cmd.scan;
   assign ev        = rd_ff.mask[2:0] & READY_MASK;
   assign ready_hit = pv_ff && (ev != 3'd0);
   assign hit       = pv_ff && (rd_ff.desc == desc_ff);
   assign adv       = !(cmd.scan && ready_hit && (cnt_ff != '0) && !out_free);
   assign issue     = walking && adv && (rq_ff < fill_ff);
   assign scan_emit = cmd.scan && adv && ready_hit;
   assign cnt_after = scan_emit ? POS_W'(cnt_ff + 1'b1) : cnt_ff;

   always_comb begin
      if (maxev_ff == 6'd0) begin
         maxeff = POS_W'(1);
      end else if (32'(maxev_ff) > 32'(LIST_DEPTH)) begin
         maxeff = POS_W'(LIST_DEPTH);
      end else begin
         maxeff = POS_W'(maxev_ff);
      end
   end

   always_comb begin
      sts            = '0;
      sts.dec        = dec;
      sts.find_hit   = cmd.find && hit;
      sts.find_miss  = cmd.find && !hit && (rq_ff >= fill_ff);
      sts.is_del     = (op_ff == OP_DEL);
      sts.shift_done = cmd.shift && !pv_ff && (rq_ff >= fill_ff);
      sts.scan_done  = cmd.scan && adv && ((cnt_after >= maxeff) || (rq_ff >= fill_ff));
      sts.out_free   = out_free;
   end

   // memory write port
   logic              we;
   logic [ADDR_W-1:0] waddr;
   entry_type         wdata;

   always_comb begin
      we    = 1'b0;
      waddr = ent_addr(lst_ff, pidx_ff[IDX_W-1:0]);
      wdata = '{desc: desc_ff, mask: emask_ff, data: udata_ff};
      if (sts.find_hit && op_ff == OP_MOD) begin
         we = 1'b1;
      end else if (sts.find_miss && op_ff == OP_ADD) begin
         we    = 1'b1;
         waddr = ent_addr(lst_ff, fill_ff[IDX_W-1:0]);
      end else if (cmd.shift && pv_ff) begin
         we    = 1'b1;
         waddr = ent_addr(lst_ff, IDX_W'(pidx_ff - 1'b1));
         wdata = rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (walking && adv) begin
         rd_ff <= mem[ent_addr(lst_ff, rq_ff[IDX_W-1:0])];
      end
   end

   // capture and decode registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= in_command;
         hdl_ff   <= in_handle;
         desc_ff  <= in_descriptor[DESCRIPTOR_BITS-1:0];
         emask_ff <= in_mask;
         udata_ff <= in_data;
         maxev_ff <= in_max;
      end
      if (cmd.decode) begin
         lst_ff  <= hidx;
         fill_ff <= cur_fill;
      end
   end

   // list state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LIST_COUNT; i++) begin
            use_ff[i]  <= 1'b0;
            fcnt_ff[i] <= '0;
         end
      end else begin
         if (cmd.decode && op_ff == OP_ALLOC && free_found) begin
            use_ff[free_idx]  <= 1'b1;
            fcnt_ff[free_idx] <= '0;
         end
         if (sts.find_miss && op_ff == OP_ADD) begin
            fcnt_ff[lst_ff] <= POS_W'(fill_ff + 1'b1);
         end
         if (sts.shift_done) begin
            fcnt_ff[lst_ff] <= POS_W'(fill_ff - 1'b1);
         end
      end
   end

   // walk pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff   <= 1'b0;
         rq_ff   <= '0;
         pidx_ff <= '0;
         cnt_ff  <= '0;
      end else if (cmd.decode) begin
         pv_ff  <= 1'b0;
         rq_ff  <= '0;
         cnt_ff <= '0;
      end else if (sts.find_hit) begin
         // delete: restart the walk just past the removed entry
         pv_ff <= 1'b0;
         rq_ff <= POS_W'(pidx_ff + 1'b1);
      end else if (walking && adv) begin
         pv_ff   <= issue;
         pidx_ff <= rq_ff;
         rq_ff   <= issue ? POS_W'(rq_ff + 1'b1) : rq_ff;
         cnt_ff  <= cnt_after;
      end
   end

   // pending result
   always_ff @(posedge clock) begin
      if (cmd.decode) begin
         hst_ff  <= dec_st;
         hval_ff <= dec_val;
         hev_ff  <= '0;
         hdat_ff <= '0;
      end else if (sts.find_hit && op_ff == OP_ADD) begin
         hst_ff <= ST_PRESENT;
      end else if (sts.find_miss && op_ff != OP_ADD) begin
         hst_ff <= ST_NOT_FOUND;
      end else if (scan_emit) begin
         hst_ff  <= ST_OK;
         hval_ff <= 10'(cnt_ff + 1'b1);
         hev_ff  <= ev;
         hdat_ff <= rd_ff.data;
      end
   end

   // output register: earlier ready entries leave as soon as the next one is found
   logic oload, olast;

   assign oload = (cmd.reply && out_free) || (scan_emit && cnt_ff != '0);
   assign olast = cmd.reply;

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
      end else if (oload) begin
         ov_ff <= 1'b1;
      end else if (rsp_tready) begin
         ov_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (oload) begin
         ost_ff   <= hst_ff;
         oval_ff  <= hval_ff;
         oev_ff   <= hev_ff;
         odat_ff  <= hdat_ff;
         olast_ff <= olast;
      end
   end

   assign rsp_tvalid = ov_ff;
   assign out_status = ost_ff;
   assign out_value  = oval_ff;
   assign out_evbits = oev_ff;
   assign out_data   = odat_ff;
   assign out_last   = olast_ff;

endmodule
`default_nettype wire
